// ----- rtl/bms_pkg.sv -----
package bms_pkg;

	// Command codes carried in the request
	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_MIN  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// Status codes returned with every result
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		cmd_t   cmd;
		value_t value;
	} req_t;

	typedef struct packed {
		status_t              status;
		value_t               min_value;
		logic [COUNT_W-1:0]   count;
		logic                 is_empty;
		logic                 is_full;
	} rsp_t;

endpackage

// ----- rtl/bms_chan_if.sv -----
interface bms_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/bms_ram.sv -----
module bms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port with enable
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bounded_min_stack_unit.sv -----
// Bounded stack of signed 32-bit values with a minimum query. Each request is
// a command (push, pop, minimum query, no-op); each produces exactly one result
// with a status, the minimum (non-zero only on a successful query), the count
// after the command and the empty and full flags. A push when full reports
// overflow, a pop when empty underflow, a query on an empty stack empty; none
// of them changes the stack. On acceptance the running minimum of the current
// top is read from the prefix-minimum RAM (registered read port); in the execute
// state the signed comparator forms the new running minimum, the RAM is written
// on a push and the result register is loaded. The next request is taken once
// the block is back in idle; a finished result waits in the output register,
// and the block holds in S_EXEC only while that register is still occupied.
module bounded_min_stack_unit #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bms_chan_if.sink   req,
	bms_chan_if.source rsp
);

	import bms_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   fill_q;
	cmd_t               cmd_q;
	value_t             value_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [CNT_W-1:0]   fill_dec;
	logic [CNT_W-1:0]   fill_nxt;
	logic               accept;
	logic               out_free;
	logic               finish;
	logic               ram_re;
	logic               ram_we;
	value_t             ram_rdata;
	value_t             run_min;
	logic               val_less;
	status_t            status_nxt;
	value_t             min_nxt;
	logic               is_empty;
	logic               is_full;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == S_EXEC) && out_free;

	assign is_empty  = (fill_q == '0);
	assign is_full   = (fill_q == CNT_W'(DEPTH));
	assign fill_dec  = fill_q - CNT_W'(1);

	// read the running minimum of the current top on acceptance
	assign ram_re = accept && !is_empty;

	// signed comparator: new value against the running minimum
	assign val_less = value_q < ram_rdata;
	assign run_min  = (is_empty || val_less) ? value_q : ram_rdata;

	// command decode
	always_comb begin
		status_nxt = ST_OK;
		min_nxt    = '0;
		fill_nxt   = fill_q;
		ram_we     = 1'b0;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (is_full) begin
					status_nxt = ST_OVERFLOW;
				end else begin
					fill_nxt = fill_q + CNT_W'(1);
					ram_we   = finish;
				end
			end
			CMD_POP: begin
				if (is_empty) begin
					status_nxt = ST_UNDERFLOW;
				end else begin
					fill_nxt = fill_dec;
				end
			end
			CMD_MIN: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					min_nxt = ram_rdata;
				end
			end
			CMD_NOP: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	bms_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_min_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (run_min),
		.re    (ram_re),
		.raddr (fill_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	// sequencer, fill count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cmd_q       <= CMD_NOP;
			value_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// result held until taken; a new one may replace it in the same cycle
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= req.payload.cmd;
						value_q <= req.payload.value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						fill_q             <= fill_nxt;
						rsp_q.status       <= status_nxt;
						rsp_q.min_value    <= min_nxt;
						rsp_q.count        <= COUNT_W'(fill_nxt);
						rsp_q.is_empty     <= (fill_nxt == '0);
						rsp_q.is_full      <= (fill_nxt == CNT_W'(DEPTH));
						state_q            <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// fill count stays within the stack depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	// fill count only moves when a result is produced
	a_fill_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> $past(finish))
		else $error("fill count changed without a result");

	// overflow is only reported with a full stack
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.status == ST_OVERFLOW) |-> rsp.payload.is_full)
		else $error("overflow reported while not full");

	// underflow and empty-query are only reported with an empty stack
	a_udf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.payload.status == ST_UNDERFLOW ||
			rsp.payload.status == ST_EMPTY)) |-> rsp.payload.is_empty)
		else $error("underflow or empty reported on non-empty stack");

	// no request is taken while a command is in progress
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC) && !req.ready)
		else $error("request taken during command");

endmodule
